### rtl/llri_pkg.sv
// ----------------------------------------------------------------------------
// Log record latest index package
// Shared item and result types, operation and status codes, and defaults.
// ----------------------------------------------------------------------------
package llri_pkg;

	localparam int CAPACITY_DEF    = 64;
	localparam int KEY_BITS_DEF    = 64;
	localparam int PAGE_BYTES_DEF  = 256;
	localparam int ARENA_BYTES_DEF = 65536;

	localparam logic [31:0] RECORD_MAGIC   = 32'h3144_4150;
	localparam logic [15:0] FLAGS_DATA     = 16'd0;
	localparam logic [15:0] FLAGS_TOMB     = 16'd1;

	localparam int OFF_OUT_W   = 17;
	localparam int COUNT_OUT_W = 7;

	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_RECORD = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	localparam logic [3:0] STAT_OK       = 4'd0;
	localparam logic [3:0] STAT_LOG_END  = 4'd1;
	localparam logic [3:0] STAT_TAINTED  = 4'd2;
	localparam logic [3:0] STAT_INVALID  = 4'd3;
	localparam logic [3:0] STAT_ADDED    = 4'd4;
	localparam logic [3:0] STAT_UPDATED  = 4'd5;
	localparam logic [3:0] STAT_OLDER    = 4'd6;
	localparam logic [3:0] STAT_OVERFLOW = 4'd7;
	localparam logic [3:0] STAT_ENDED    = 4'd8;

	typedef struct packed {
		logic [1:0]  operation;
		logic        blank_page;
		logic [31:0] record_magic;
		logic [63:0] record_key;
		logic [15:0] record_flags;
		logic [31:0] record_size;
		logic [31:0] record_generation;
		logic [31:0] stored_crc;
		logic [31:0] payload_crc;
	} llri_item_t;

	typedef struct packed {
		logic [3:0]             status;
		logic                   entry_found;
		logic [OFF_OUT_W-1:0]   entry_offset;
		logic [OFF_OUT_W-1:0]   entry_bytes;
		logic                   entry_tombstone;
		logic [31:0]            entry_generation;
		logic [OFF_OUT_W-1:0]   next_offset;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic [31:0]            max_generation;
		logic                   tainted;
		logic                   overflow;
	} llri_result_t;

	typedef struct packed {
		logic done;
		logic hit;
	} llri_scan_stat_t;

endpackage

### rtl/llri_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module llri_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/llri_scan.sv
// ----------------------------------------------------------------------------
// Log record latest index key search
// Walks the used table entries one read per cycle and reports hit or miss.
// ----------------------------------------------------------------------------
module llri_scan #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 64
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          go,
	input  logic [$clog2(CAPACITY+1)-1:0]                 count,
	input  logic [KEY_BITS-1:0]                           key,
	input  logic [KEY_BITS-1:0]                           rd_key,
	output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] raddr,
	output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] hit_idx,
	output llri_pkg::llri_scan_stat_t                     stat
);

	import llri_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY+1);

	logic          active_q;
	logic [CW-1:0] ptr_q;
	logic          pend_s1;
	logic [AW-1:0] addr_s1;
	logic          issue;
	logic          hit;
	logic          miss;

	assign issue   = active_q && (ptr_q < count);
	assign hit     = active_q && pend_s1 && (rd_key == key);
	assign miss    = active_q && !pend_s1 && !issue;
	assign raddr   = ptr_q[AW-1:0];
	assign hit_idx = addr_s1;
	assign stat.done = hit || miss;
	assign stat.hit  = hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ptr_q    <= '0;
			pend_s1  <= 1'b0;
		end else if (go) begin
			active_q <= 1'b1;
			ptr_q    <= '0;
			pend_s1  <= 1'b0;
		end else if (active_q) begin
			pend_s1 <= issue;
			if (issue) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (hit || miss) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= ptr_q[AW-1:0];
	end

endmodule

### rtl/log_record_latest_index.sv
// ----------------------------------------------------------------------------
// Log record latest index
// Scans record headers of an append-only flash log and keeps, per key, the
// newest record in a table held in RAM; answers key lookups from that table.
//
//   channel  | ports                  | handshake
//   ---------+------------------------+--------------------------------------
//   item     | start, busy, item      | taken when start is high, busy low
//   result   | done, result           | one-cycle strobe per item, cannot be stalled
//
// Start and no-op items, and records that end the scan or come after its end,
// go from the check step straight to the reply; invalid records first pass
// the update step. Records that reach the table and lookups pass the check,
// key search, update and reply steps; the key search reads one RAM entry per
// cycle and stops at the key or after the last used entry.
// busy stays high until the result strobe, when the next item may be taken.
// Reset clears the counters and flags; the table needs no clearing pass.
// ----------------------------------------------------------------------------
module log_record_latest_index #(
	parameter int CAPACITY    = llri_pkg::CAPACITY_DEF,
	parameter int KEY_BITS    = llri_pkg::KEY_BITS_DEF,
	parameter int PAGE_BYTES  = llri_pkg::PAGE_BYTES_DEF,
	parameter int ARENA_BYTES = llri_pkg::ARENA_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  llri_pkg::llri_item_t   item,
	output logic                   done,
	output llri_pkg::llri_result_t result
);

	import llri_pkg::*;

	localparam int AW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW        = $clog2(CAPACITY+1);
	localparam int OW        = $clog2(ARENA_BYTES+1);
	localparam int KEY_BYTES = (KEY_BITS + 7) / 8;
	localparam int HDR_BYTES = ((((4 + KEY_BYTES + 1) / 2) * 2 + 4 + 3) / 4) * 4 + 12;
	localparam int EW        = KEY_BITS + 32 + 2*OW + 1;
	localparam int LEN_LO    = 1;
	localparam int OFF_LO    = OW + 1;
	localparam int GEN_LO    = 2*OW + 1;
	localparam int KEY_LO    = 2*OW + 33;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_SEARCH = 3'd2;
	localparam logic [2:0] S_UPDATE = 3'd3;
	localparam logic [2:0] S_REPLY  = 3'd4;

	logic [2:0]    state_q;
	llri_item_t    item_q;
	logic [CW-1:0] used_q;
	logic [OW-1:0] off_q;
	logic [OW-1:0] rem_q;
	logic [31:0]   maxgen_q;
	logic          taint_q;
	logic          ovf_q;
	logic          ended_q;
	logic          inval_q;
	logic [OW-1:0] bytes_q;
	logic [3:0]    status_q;
	logic          found_q;
	logic [OW-1:0] eoff_q;
	logic [OW-1:0] elen_q;
	logic          etomb_q;
	logic [31:0]   egen_q;
	logic          hit_q;
	logic [AW-1:0] hidx_q;
	logic [EW-1:0] hentry_q;
	logic          done_q;
	llri_result_t  result_q;

	logic [KEY_BITS-1:0] key_c;
	logic [32:0]         bytes_c;
	logic                size_bad;
	logic                bytes_bad;
	logic                flags_bad;
	logic                log_end;
	logic                hdr_bad;
	logic [31:0]         gen_diff;
	logic                newer;
	logic                is_record;
	logic                scan_go;
	logic [AW-1:0]       ram_raddr;
	logic [EW-1:0]       ram_rdata;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [EW-1:0]       ram_wdata;
	logic [AW-1:0]       scan_idx;
	llri_scan_stat_t     scan_stat;

	assign key_c     = item_q.record_key[KEY_BITS-1:0];
	assign is_record = (item_q.operation == OP_RECORD);
	assign bytes_c   = (33'(item_q.record_size) + 33'(HDR_BYTES + PAGE_BYTES - 1))
		& ~33'(PAGE_BYTES - 1);
	assign size_bad  = 33'(item_q.record_size) > 33'(rem_q - OW'(HDR_BYTES));
	assign bytes_bad = bytes_c > 33'(rem_q);
	assign flags_bad = (item_q.record_flags > FLAGS_TOMB)
		|| ((item_q.record_flags == FLAGS_TOMB)
			&& ((item_q.record_size != 32'd0) || (item_q.stored_crc != 32'd0)))
		|| ((item_q.record_flags == FLAGS_DATA)
			&& (item_q.stored_crc != item_q.payload_crc));
	assign log_end   = (rem_q < OW'(PAGE_BYTES)) || item_q.blank_page;
	assign hdr_bad   = (item_q.record_magic != RECORD_MAGIC) || size_bad || bytes_bad;
	assign gen_diff  = item_q.record_generation - hentry_q[GEN_LO +: 32];
	assign newer     = (gen_diff != 32'd0) && !gen_diff[31];

	assign scan_go = (state_q == S_CHECK) && (item_q.operation == OP_LOOKUP
		|| (is_record && !ended_q && (rem_q >= OW'(PAGE_BYTES)) && !item_q.blank_page
			&& (item_q.record_magic == RECORD_MAGIC) && !size_bad && !bytes_bad
			&& !flags_bad));

	assign ram_we    = (state_q == S_UPDATE) && is_record && !inval_q
		&& (hit_q ? newer : (used_q < CW'(CAPACITY)));
	assign ram_waddr = hit_q ? hidx_q : used_q[AW-1:0];
	assign ram_wdata = {key_c, item_q.record_generation, off_q, bytes_q,
		(item_q.record_flags == FLAGS_TOMB)};

	llri_scan #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (scan_go),
		.count   (used_q),
		.key     (key_c),
		.rd_key  (ram_rdata[KEY_LO +: KEY_BITS]),
		.raddr   (ram_raddr),
		.hit_idx (scan_idx),
		.stat    (scan_stat)
	);

	llri_ram #(
		.WIDTH (EW),
		.DEPTH (CAPACITY)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			used_q   <= '0;
			off_q    <= OW'(2*PAGE_BYTES);
			rem_q    <= OW'(ARENA_BYTES - 2*PAGE_BYTES);
			maxgen_q <= '0;
			taint_q  <= 1'b0;
			ovf_q    <= 1'b0;
			ended_q  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= (state_q == S_REPLY);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					case (item_q.operation)
						OP_START: begin
							state_q <= S_REPLY;
							used_q  <= '0;
							off_q   <= OW'(2*PAGE_BYTES);
							rem_q   <= OW'(ARENA_BYTES - 2*PAGE_BYTES);
							taint_q <= 1'b0;
							ovf_q   <= 1'b0;
							ended_q <= 1'b0;
						end
						OP_RECORD: begin
							if (ended_q) begin
								state_q <= S_REPLY;
							end else if (log_end) begin
								state_q <= S_REPLY;
								ended_q <= 1'b1;
							end else if (hdr_bad) begin
								state_q <= S_REPLY;
								taint_q <= 1'b1;
								ended_q <= 1'b1;
							end else if (flags_bad) begin
								state_q <= S_UPDATE;
							end else begin
								if (item_q.record_generation > maxgen_q) begin
									maxgen_q <= item_q.record_generation;
								end
								state_q <= S_SEARCH;
							end
						end
						OP_LOOKUP: begin
							state_q <= S_SEARCH;
						end
						default: begin
							state_q <= S_REPLY;
						end
					endcase
				end
				S_SEARCH: begin
					if (scan_stat.done) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					state_q <= S_REPLY;
					if (is_record) begin
						off_q <= off_q + bytes_q;
						rem_q <= rem_q - bytes_q;
						if (!inval_q && !hit_q) begin
							if (used_q < CW'(CAPACITY)) begin
								used_q <= used_q + CW'(1);
							end else begin
								ovf_q <= 1'b1;
							end
						end
					end
				end
				S_REPLY: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && start) begin
			item_q <= item;
		end
		if (state_q == S_CHECK) begin
			bytes_q  <= bytes_c[OW-1:0];
			inval_q  <= is_record && !ended_q && !log_end && !hdr_bad && flags_bad;
			found_q  <= 1'b0;
			eoff_q   <= '0;
			elen_q   <= '0;
			etomb_q  <= 1'b0;
			egen_q   <= '0;
			if (is_record && ended_q) begin
				status_q <= STAT_ENDED;
			end else if (is_record && log_end) begin
				status_q <= STAT_LOG_END;
			end else if (is_record && hdr_bad) begin
				status_q <= STAT_TAINTED;
			end else begin
				status_q <= STAT_OK;
			end
		end
		if ((state_q == S_SEARCH) && scan_stat.done) begin
			hit_q    <= scan_stat.hit;
			hidx_q   <= scan_idx;
			hentry_q <= ram_rdata;
		end
		if (state_q == S_UPDATE) begin
			if (!is_record) begin
				found_q <= hit_q;
				if (hit_q) begin
					eoff_q  <= hentry_q[OFF_LO +: OW];
					elen_q  <= hentry_q[LEN_LO +: OW];
					etomb_q <= hentry_q[0];
					egen_q  <= hentry_q[GEN_LO +: 32];
				end
			end else if (inval_q) begin
				status_q <= STAT_INVALID;
			end else if (hit_q) begin
				status_q <= newer ? STAT_UPDATED : STAT_OLDER;
			end else begin
				status_q <= (used_q < CW'(CAPACITY)) ? STAT_ADDED : STAT_OVERFLOW;
			end
		end
		if (state_q == S_REPLY) begin
			result_q.status           <= status_q;
			result_q.entry_found      <= found_q;
			result_q.entry_offset     <= OFF_OUT_W'(eoff_q);
			result_q.entry_bytes      <= OFF_OUT_W'(elen_q);
			result_q.entry_tombstone  <= etomb_q;
			result_q.entry_generation <= egen_q;
			result_q.next_offset      <= OFF_OUT_W'(off_q);
			result_q.entry_count      <= COUNT_OUT_W'(used_q);
			result_q.max_generation   <= maxgen_q;
			result_q.tainted          <= taint_q;
			result_q.overflow         <= ovf_q;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("Result strobe raised while an item is still in work.");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(CAPACITY))
		else $error("Entry count exceeds the table capacity.");

	a_taint_ends: assert property (@(posedge clk) disable iff (!arst_n)
		taint_q |-> ended_q)
		else $error("Tainted scan was not marked as ended.");

	a_offset_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(OW+1)'(off_q) + (OW+1)'(rem_q) == (OW+1)'(ARENA_BYTES))
		else $error("Append offset and remaining room disagree.");

	a_write_update: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (state_q == S_REPLY))
		else $error("Table write outside the update step.");
`endif

endmodule
